/* rtl/csao_pkg.sv */
// Shared types and constants for the cursor sprite overlay.
// Sprite geometry, register indexes, overlay modes and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package csao_pkg;

	localparam int SPRITE_SIDE     = 64;
	localparam int SIDE_BITS       = $clog2(SPRITE_SIDE);
	localparam int ADDR_BITS       = 2 * SIDE_BITS;
	localparam int STORE_DEPTH     = SPRITE_SIDE * SPRITE_SIDE;
	localparam int MAX_FRAME_WIDTH = 16384;
	localparam int COL_BITS        = $clog2(MAX_FRAME_WIDTH);
	localparam int FW_BITS         = COL_BITS + 1;
	localparam int ROW_BITS        = 16;
	localparam int PIX_BITS        = 32;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_IDX_BITS    = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_CURSOR_LEFT   = 3'd1,
		REG_CURSOR_TOP    = 3'd2,
		REG_CURSOR_WIDTH  = 3'd3,
		REG_CURSOR_HEIGHT = 3'd4,
		REG_OVERLAY_MODE  = 3'd5,
		REG_TARGET_WIDTH  = 3'd6,
		REG_TARGET_HEIGHT = 3'd7
	} reg_idx_t;

	localparam logic [1:0] MODE_OFF         = 2'd0;
	localparam logic [1:0] MODE_ALWAYS      = 2'd1;
	localparam logic [1:0] MODE_HIDE_OUTSIDE = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	typedef struct packed {
		logic [14:0]        frame_width;
		logic signed [15:0] cursor_left;
		logic signed [15:0] cursor_top;
		logic [6:0]         cursor_width;
		logic [6:0]         cursor_height;
		logic [1:0]         overlay_mode;
		logic [14:0]        target_width;
		logic [14:0]        target_height;
	} cfg_t;

endpackage

/* rtl/csao_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module csao_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/csao_pos.sv */
// Raster position tracking and cursor hit test.
// Holds the column and row counters and forms the sprite read address.
// Depends on csao_pkg.
`timescale 1ns / 1ps

module csao_pos import csao_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 advance,
	input  logic                 frame_start,
	output logic                 hit,
	output logic [ADDR_BITS-1:0] rd_addr
);

	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_eff;
	logic [ROW_BITS-1:0] row_eff;
	logic [FW_BITS-1:0]  fw_eff;
	logic [FW_BITS-1:0]  col_inc;
	logic signed [17:0]  dx;
	logic signed [17:0]  dy;
	logic [6:0]          cw;
	logic [6:0]          ch;
	logic                draw;

	localparam logic [6:0]         SIDE_W  = 7'(SPRITE_SIDE);
	localparam logic [FW_BITS-1:0] FW_MAX  = FW_BITS'(MAX_FRAME_WIDTH);
	localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

	always_comb begin
		col_eff = frame_start ? '0 : col_q;
		row_eff = frame_start ? '0 : row_q;

		if (cfg.frame_width == '0) begin
			fw_eff = FW_BITS'(1);
		end else if (FW_BITS'(cfg.frame_width) > FW_MAX) begin
			fw_eff = FW_MAX;
		end else begin
			fw_eff = FW_BITS'(cfg.frame_width);
		end
		col_inc = FW_BITS'(col_eff) + FW_BITS'(1);

		cw = (cfg.cursor_width > SIDE_W) ? SIDE_W : cfg.cursor_width;
		ch = (cfg.cursor_height > SIDE_W) ? SIDE_W : cfg.cursor_height;

		draw = (cfg.overlay_mode == MODE_ALWAYS) ||
			((cfg.overlay_mode == MODE_HIDE_OUTSIDE) &&
			!cfg.cursor_left[15] && !cfg.cursor_top[15] &&
			(cfg.cursor_left[14:0] < cfg.target_width) &&
			(cfg.cursor_top[14:0] < cfg.target_height));

		dx = $signed(18'(col_eff)) - 18'(cfg.cursor_left);
		dy = $signed(18'(row_eff)) - 18'(cfg.cursor_top);

		hit = draw && !dx[17] && !dy[17] &&
			(dx[16:0] < 17'(cw)) && (dy[16:0] < 17'(ch));
		rd_addr = {dy[SIDE_BITS-1:0], dx[SIDE_BITS-1:0]};
	end

	// Wrap the column at the frame width, saturate the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_inc >= fw_eff) begin
				col_q <= '0;
				row_q <= (row_eff == ROW_MAX) ? row_eff : row_eff + ROW_BITS'(1);
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
				row_q <= row_eff;
			end
		end
	end

endmodule

/* rtl/csao_blend.sv */
// Per-channel alpha blend of sprite over frame pixel (frame passes when disabled).
// floor((c*a + f*(255-a))/255) on blue, green and red; alpha forced to 255.
// Depends on csao_pkg.
`timescale 1ns / 1ps

module csao_blend import csao_pkg::*; (
	input  logic                enable,
	input  logic [PIX_BITS-1:0] sprite,
	input  logic [PIX_BITS-1:0] frame,
	output logic [PIX_BITS-1:0] result
);

	logic [7:0]  alpha;
	logic [7:0]  inv_alpha;
	logic [15:0] mix [3];
	logic [16:0] sum [3];
	logic [PIX_BITS-1:0] blended;

	always_comb begin
		alpha     = sprite[31:24];
		inv_alpha = 8'hFF - alpha;
		blended   = {8'hFF, 24'h0};
		for (int ch = 0; ch < 3; ch++) begin
			mix[ch] = 16'(sprite[ch*8 +: 8] * alpha) + 16'(frame[ch*8 +: 8] * inv_alpha);
			// exact floor divide by 255 for every sum that can occur here (at most 255*255)
			sum[ch] = 17'(mix[ch]) + 17'(mix[ch][15:8]) + 17'd1;
			blended[ch*8 +: 8] = sum[ch][15:8];
		end
		result = enable ? blended : frame;
	end

endmodule

/* rtl/cursor_sprite_alpha_overlay.sv */
// Top level of the cursor sprite overlay.
// Instantiates csao_pos, csao_ram and csao_blend; depends on csao_pkg.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries two kinds of beat. A load beat
// (cmd = 0) writes pixel_in into the 64x64 sprite store at sprite_index and
// gives no result. A frame beat (cmd = 1) carries one BGRA raster pixel; its
// composited value leaves on the output channel (out_valid/out_ready) as
// pixel_out. frame_start on a frame beat puts that pixel at column 0, row 0.
// Registers must be written through cfg_we/cfg_index/cfg_wdata only while idle;
// the user keeps to this, the block does not enforce it. At the accepting edge
// a frame beat's sprite store read is issued and its hit and pixel enter the
// read stage; the blend is combinational and lands in the output register
// when the read stage moves on. Throughput: one beat per cycle, loads and frame
// pixels alike, while in_ready is high; a sprite entry may be read in the
// cycle right after it was loaded. When the receiver stalls, the output
// register and read stage hold their data; loads are still taken, one more
// frame beat fills the read stage, then in_ready drops until the output moves.
// Reset clears the counters, pipeline valids and registers to their defaults;
// the sprite store is not cleared and must be loaded before it is shown.

module cursor_sprite_alpha_overlay import csao_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic [PIX_BITS-1:0]      pixel_in,
	input  logic [11:0]              sprite_index,
	input  logic                     frame_start,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PIX_BITS-1:0]      pixel_out
);

	cfg_t                cfg_q;
	logic                adv;
	logic                accept;
	logic                frame_acc;
	logic                load_we;
	logic                hit;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [PIX_BITS-1:0] sprite_rd;
	logic [PIX_BITS-1:0] blend_pix;
	logic                valid_s1;
	logic                hit_s1;
	logic [PIX_BITS-1:0] pixel_s1;
	logic                out_valid_q;
	logic [PIX_BITS-1:0] pixel_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= 15'd1920;
			cfg_q.cursor_left   <= '0;
			cfg_q.cursor_top    <= '0;
			cfg_q.cursor_width  <= '0;
			cfg_q.cursor_height <= '0;
			cfg_q.overlay_mode  <= MODE_OFF;
			cfg_q.target_width  <= 15'd1920;
			cfg_q.target_height <= 15'd1080;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_wdata[14:0];
				REG_CURSOR_LEFT:   cfg_q.cursor_left   <= $signed(cfg_wdata);
				REG_CURSOR_TOP:    cfg_q.cursor_top    <= $signed(cfg_wdata);
				REG_CURSOR_WIDTH:  cfg_q.cursor_width  <= cfg_wdata[6:0];
				REG_CURSOR_HEIGHT: cfg_q.cursor_height <= cfg_wdata[6:0];
				REG_OVERLAY_MODE:  cfg_q.overlay_mode  <= cfg_wdata[1:0];
				REG_TARGET_WIDTH:  cfg_q.target_width  <= cfg_wdata[14:0];
				REG_TARGET_HEIGHT: cfg_q.target_height <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// The read stage moves on when the output register is free or being drained.
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign accept    = in_valid && in_ready;
	assign frame_acc = accept && (cmd == CMD_FRAME);
	assign load_we   = accept && (cmd == CMD_LOAD) && (int'(sprite_index) < STORE_DEPTH);

	csao_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.advance     (frame_acc),
		.frame_start (frame_start),
		.hit         (hit),
		.rd_addr     (rd_addr)
	);

	csao_ram #(
		.WIDTH (PIX_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (ADDR_BITS'(sprite_index)),
		.wdata (pixel_in),
		.re    (frame_acc),
		.raddr (rd_addr),
		.rdata (sprite_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= frame_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			hit_s1   <= hit;
			pixel_s1 <= pixel_in;
		end
	end

	csao_blend u_blend (
		.enable (hit_s1),
		.sprite (sprite_rd),
		.frame  (pixel_s1),
		.result (blend_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			pixel_out_q <= blend_pix;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

endmodule

/* tb/tb_cursor_sprite_alpha_overlay.sv */
// Self-checking testbench for cursor_sprite_alpha_overlay.
// Drives sprite loads and raster pixels over valid/ready, predicts each composited
// pixel from its own shadow of the registers, position and sprite store; needs csao_pkg.
`timescale 1ns / 1ps

module tb_cursor_sprite_alpha_overlay;
	import csao_pkg::*;

	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int BATCH_HALF = 11;
	localparam int RANDOM_SETTINGS = 7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

	typedef struct {
		logic              cmd;
		logic [PIX_BITS-1:0] pixel;
		logic [11:0]       index;
		logic              fstart;
	} beat_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     cmd = CMD_LOAD;
	logic [PIX_BITS-1:0]      pixel_in = '0;
	logic [11:0]              sprite_index = '0;
	logic                     frame_start = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [PIX_BITS-1:0]      pixel_out;

	cursor_sprite_alpha_overlay dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.pixel_in     (pixel_in),
		.sprite_index (sprite_index),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_out    (pixel_out)
	);

	always #5 clk = ~clk;

	// Register settings: frame_width, left, top, width, height, mode, target w, target h.
	int fixed_settings [0:12][0:7] = '{
		'{0,     0,      0,      64,  64,  MODE_ALWAYS,       1920,  1080},
		'{32767, 3,      0,      127, 1,   MODE_ALWAYS,       16384, 16384},
		'{8,     -2,     -3,     5,   6,   MODE_ALWAYS,       0,     0},
		'{8,     -2,     -3,     5,   6,   MODE_HIDE_OUTSIDE, 16384, 16384},
		'{8,     2,      1,      4,   4,   MODE_HIDE_OUTSIDE, 0,     0},
		'{8,     2,      1,      4,   4,   MODE_HIDE_OUTSIDE, 3,     2},
		'{8,     3,      1,      4,   4,   MODE_HIDE_OUTSIDE, 3,     2},
		'{8,     0,      0,      8,   8,   MODE_RESERVED,     16384, 16384},
		'{8,     0,      0,      8,   8,   MODE_OFF,          16384, 16384},
		'{16384, 32767,  32767,  64,  64,  MODE_ALWAYS,       32767, 32767},
		'{5,     -32768, -32768, 64,  64,  MODE_ALWAYS,       32767, 32767},
		'{6,     0,      0,      0,   64,  MODE_ALWAYS,       16384, 16384},
		'{7,     5,      2,      3,   127, MODE_HIDE_OUTSIDE, 32767, 32767}
	};

	idle_t idle_mode = IDLE_NONE;
	beat_t pending_beats [$];
	logic [PIX_BITS-1:0] expected_pixels [$];
	int beats_queued = 0;
	int beats_taken = 0;
	int errors = 0;
	int loads_taken = 0;
	int pixels_checked = 0;
	int phases_run = 0;

	// Predictor state, advanced on accepted beats.
	cfg_t shadow_cfg;
	logic [PIX_BITS-1:0] sprite_mirror [0:STORE_DEPTH-1];
	logic [COL_BITS-1:0] pred_col = '0;
	logic [ROW_BITS-1:0] pred_row = '0;

	// Generator-side position, used only to load sprite entries before they are read.
	logic [COL_BITS-1:0] gen_col = '0;
	logic [ROW_BITS-1:0] gen_row = '0;
	bit sprite_loaded [0:STORE_DEPTH-1];

	function automatic bit sprite_hit(cfg_t c, logic [COL_BITS-1:0] col,
			logic [ROW_BITS-1:0] row, output int addr);
		int dx, dy, cw, ch;
		bit shown;
		shown = (c.overlay_mode == MODE_ALWAYS) ||
			(c.overlay_mode == MODE_HIDE_OUTSIDE && c.cursor_left >= 0 &&
			c.cursor_top >= 0 && int'(c.cursor_left) < int'(c.target_width) &&
			int'(c.cursor_top) < int'(c.target_height));
		dx = int'(col) - int'(c.cursor_left);
		dy = int'(row) - int'(c.cursor_top);
		cw = (c.cursor_width > SPRITE_SIDE) ? SPRITE_SIDE : int'(c.cursor_width);
		ch = (c.cursor_height > SPRITE_SIDE) ? SPRITE_SIDE : int'(c.cursor_height);
		addr = dy * SPRITE_SIDE + dx;
		return shown && dx >= 0 && dy >= 0 && dx < cw && dy < ch;
	endfunction

	function automatic void advance_pos(input cfg_t c, inout logic [COL_BITS-1:0] col,
			inout logic [ROW_BITS-1:0] row);
		int fw;
		fw = int'(c.frame_width);
		if (fw == 0)
			fw = 1;
		if (fw > MAX_FRAME_WIDTH)
			fw = MAX_FRAME_WIDTH;
		if (int'(col) + 1 >= fw) begin
			col = '0;
			if (row != '1)
				row++;
		end else begin
			col++;
		end
	endfunction

	function automatic logic [PIX_BITS-1:0] blend_bgra(logic [PIX_BITS-1:0] spr,
			logic [PIX_BITS-1:0] dst);
		int unsigned a, c, f;
		logic [PIX_BITS-1:0] res;
		a = {24'h0, spr[31:24]};
		res = 32'hFF00_0000;
		for (int sh = 0; sh < 24; sh += 8) begin
			c = (spr >> sh) & 32'hFF;
			f = (dst >> sh) & 32'hFF;
			res[sh +: 8] = 8'((c * a + f * (255 - a)) / 255);
		end
		return res;
	endfunction

	task automatic overlay_beat(beat_t b);
		int addr;
		logic [PIX_BITS-1:0] res;
		if (b.cmd == CMD_LOAD) begin
			sprite_mirror[b.index] = b.pixel;
			loads_taken++;
		end else begin
			if (b.fstart) begin
				pred_col = '0;
				pred_row = '0;
			end
			res = b.pixel;
			if (sprite_hit(shadow_cfg, pred_col, pred_row, addr))
				res = blend_bgra(sprite_mirror[addr], b.pixel);
			expected_pixels.push_back(res);
			advance_pos(shadow_cfg, pred_col, pred_row);
		end
	endtask

	function automatic logic [PIX_BITS-1:0] sprite_word();
		logic [PIX_BITS-1:0] w;
		w = $urandom;
		case ($urandom_range(3))
			0: w[31:24] = 8'h00;
			1: w[31:24] = 8'hFF;
			default: ;
		endcase
		return w;
	endfunction

	task automatic queue_load(int idx, logic [PIX_BITS-1:0] pix);
		beat_t b;
		b.cmd = CMD_LOAD;
		b.pixel = pix;
		b.index = idx[11:0];
		b.fstart = 1'($urandom_range(1));
		sprite_loaded[idx] = 1'b1;
		pending_beats.push_back(b);
		beats_queued++;
	endtask

	task automatic queue_frame(logic fs, logic [PIX_BITS-1:0] pix);
		beat_t b;
		int addr;
		if (fs) begin
			gen_col = '0;
			gen_row = '0;
		end
		// load any sprite entry this pixel will read before it is first written
		if (sprite_hit(shadow_cfg, gen_col, gen_row, addr) && !sprite_loaded[addr])
			queue_load(addr, sprite_word());
		b.cmd = CMD_FRAME;
		b.pixel = pix;
		b.index = 12'($urandom);
		b.fstart = fs;
		pending_beats.push_back(b);
		beats_queued++;
		advance_pos(shadow_cfg, gen_col, gen_row);
	endtask

	task automatic write_reg(reg_idx_t r, int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v[15:0];
		case (r)
			REG_FRAME_WIDTH:   shadow_cfg.frame_width = v[14:0];
			REG_CURSOR_LEFT:   shadow_cfg.cursor_left = v[15:0];
			REG_CURSOR_TOP:    shadow_cfg.cursor_top = v[15:0];
			REG_CURSOR_WIDTH:  shadow_cfg.cursor_width = v[6:0];
			REG_CURSOR_HEIGHT: shadow_cfg.cursor_height = v[6:0];
			REG_OVERLAY_MODE:  shadow_cfg.overlay_mode = v[1:0];
			REG_TARGET_WIDTH:  shadow_cfg.target_width = v[14:0];
			REG_TARGET_HEIGHT: shadow_cfg.target_height = v[14:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(int s [0:7]);
		write_reg(REG_FRAME_WIDTH, s[0]);
		write_reg(REG_CURSOR_LEFT, s[1]);
		write_reg(REG_CURSOR_TOP, s[2]);
		write_reg(REG_CURSOR_WIDTH, s[3]);
		write_reg(REG_CURSOR_HEIGHT, s[4]);
		write_reg(REG_OVERLAY_MODE, s[5]);
		write_reg(REG_TARGET_WIDTH, s[6]);
		write_reg(REG_TARGET_HEIGHT, s[7]);
		@(posedge clk);
		cfg_we <= 1'b0;
		phases_run++;
	endtask

	// Hold until every queued beat is taken and every pixel is back, then let
	// the pipeline settle.
	task automatic drain_all();
		do
			@(posedge clk);
		while (beats_taken != beats_queued || expected_pixels.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_batch(int n);
		int roll;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (k == 0 || roll < 5)
				queue_frame(1'b1, $urandom);
			else if (roll < 20)
				queue_load($urandom_range(STORE_DEPTH - 1), sprite_word());
			else
				queue_frame(1'b0, $urandom);
		end
	endtask

	function automatic bit sender_rests();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 66;
			IDLE_BOTH:   return $urandom_range(99) < 12;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(99) < 66;
			IDLE_BOTH:     return $urandom_range(99) < 12;
			default:       return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		beat_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_beats.size() != 0 && !sender_rests()) begin
				nb = pending_beats.pop_front();
				in_valid <= 1'b1;
				cmd <= nb.cmd;
				pixel_in <= nb.pixel;
				sprite_index <= nb.index;
				frame_start <= nb.fstart;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !receiver_stalls();
	end

	always @(posedge clk) begin
		beat_t tb;
		logic [PIX_BITS-1:0] want;
		if (arst_n && in_valid && in_ready) begin
			tb.cmd = cmd;
			tb.pixel = pixel_in;
			tb.index = sprite_index;
			tb.fstart = frame_start;
			overlay_beat(tb);
			beats_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel_out %08h arrived with no pixel expected", pixel_out);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				pixels_checked++;
				if (pixel_out !== want) begin
					$error("pixel_out mismatch: expected %08h, got %08h", want, pixel_out);
					errors++;
				end
			end
		end
	end

	initial begin
		int s [0:7];
		shadow_cfg = '{frame_width: 15'd1920, cursor_left: '0, cursor_top: '0,
			cursor_width: '0, cursor_height: '0, overlay_mode: MODE_OFF,
			target_width: 15'd1920, target_height: 15'd1080};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 2x2 cursor at (1,1) in a 4-wide frame, alpha extremes.
		s = '{4, 1, 1, 2, 2, MODE_ALWAYS, 16384, 16384};
		apply_setting(s);
		queue_load(SPRITE_SIDE + 1, 32'h00FF_FFFF);
		queue_load(SPRITE_SIDE + 2, 32'hFF00_0000);
		queue_load(2 * SPRITE_SIDE + 1, 32'h80FF_00FF);
		queue_load(2 * SPRITE_SIDE + 2, 32'hFFFF_FFFF);
		queue_load(0, 32'h1234_5678);
		queue_load(STORE_DEPTH - 1, 32'hEDCB_A987);
		for (int i = 0; i < 14; i++)
			queue_frame(i == 0 || i == 10, (i % 3 == 0) ? 32'h0 :
				(i % 3 == 1) ? 32'hFFFF_FFFF : 32'h7F80_017E);
		drain_all();

		for (int p = 0; p < 13 + RANDOM_SETTINGS; p++) begin
			if (p < 13) begin
				s = fixed_settings[p];
			end else begin
				s = '{$urandom_range(12), int'($urandom_range(12)) - 4,
					int'($urandom_range(8)) - 4, $urandom_range(10),
					$urandom_range(10), $urandom_range(3),
					$urandom_range(16), $urandom_range(16)};
			end
			idle_mode = idle_t'(p % 4);
			apply_setting(s);
			random_batch(BATCH_HALF);
			// on every third setting the sender holds off until every result of the first half is back
			if (p % 3 == 0)
				drain_all();
			random_batch(BATCH_HALF);
			drain_all();
		end

		idle_mode = IDLE_BOTH;
		s = '{3, 0, 0, 2, 2, MODE_ALWAYS, 1920, 1080};
		apply_setting(s);
		random_batch(2 * BATCH_HALF);
		drain_all();

		$display("Ran %0d register settings with all four idle patterns: %0d sprite loads,",
			phases_run, loads_taken);
		$display("%0d composited pixels checked across clipped, hidden and blended cursors.",
			pixels_checked);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d pixels still expected", expected_pixels.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
rtl/csao_pkg.sv
rtl/csao_ram.sv
rtl/csao_pos.sv
rtl/csao_blend.sv
rtl/cursor_sprite_alpha_overlay.sv
tb/tb_cursor_sprite_alpha_overlay.sv
